// ----- design/assert_macros.svh -----
// Assertion macros shared by the escape decoder RTL.
// Clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// label: property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// label: condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/cssd_pkg.sv -----
// Shared types, codes and UTF-8 helpers of the CSS escape decoder.
// No dependencies.
package cssd_pkg;

    localparam int QDEPTH = 4;

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_BSL     = 3'd1;
    localparam logic [2:0] MODE_HEX     = 3'd2;
    localparam logic [2:0] MODE_CR      = 3'd3;
    localparam logic [2:0] MODE_SWALLOW = 3'd4;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [23:0] CP_MAX     = 24'h10FFFF;
    localparam logic [23:0] CP_SUR_LO  = 24'h00D800;
    localparam logic [23:0] CP_SUR_HI  = 24'h00DFFF;
    localparam logic [20:0] CP_REPLACE = 21'h00FFFD;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // one decoded input byte: code point bytes first, then a plain byte
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  cp_len;
        logic        plain_v;
        logic [7:0]  plain;
        logic        last;
    } cmd_t;

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [2:0] idx);
        logic [7:0] r;
        r = cp[7:0];
        case (len)
            3'd2:
                r = (idx == 3'd0) ? (LEAD2 | {3'b000, cp[10:6]}) : (CONT | {2'b00, cp[5:0]});
            3'd3:
                case (idx)
                    3'd0:    r = LEAD3 | {4'b0000, cp[15:12]};
                    3'd1:    r = CONT | {2'b00, cp[11:6]};
                    default: r = CONT | {2'b00, cp[5:0]};
                endcase
            3'd4:
                case (idx)
                    3'd0:    r = LEAD4 | {5'b00000, cp[20:18]};
                    3'd1:    r = CONT | {2'b00, cp[17:12]};
                    3'd2:    r = CONT | {2'b00, cp[11:6]};
                    default: r = CONT | {2'b00, cp[5:0]};
                endcase
            default: r = cp[7:0];
        endcase
        return r;
    endfunction

endpackage

// ----- design/cssd_front.sv -----
// Front end: accept raw bytes, track escape state, build decode commands.
// Depends on cssd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cssd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic               q_full,
    output logic               in_ready,
    output logic               push,
    output cssd_pkg::cmd_t     cmd
);

    logic [2:0]  mode_reg, mode_next;
    logic [23:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;

    logic        accept;
    logic        is_hex, is_ws, do_normal, emit_cp;
    logic [3:0]  digit;
    logic [23:0] cp_raw, cp_shift;
    logic [20:0] cp_fix;
    logic [2:0]  cp_len;
    logic        plain_v;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        is_hex = 1'b1;
        digit  = in_byte[3:0];
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            digit = in_byte[3:0];
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
            digit = 4'(in_byte - 8'h57);
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
            digit = 4'(in_byte - 8'h37);
        else
            is_hex = 1'b0;
        is_ws = (in_byte == cssd_pkg::CH_TAB) || (in_byte == cssd_pkg::CH_LF) ||
                (in_byte == cssd_pkg::CH_FF) || (in_byte == cssd_pkg::CH_CR) ||
                (in_byte == cssd_pkg::CH_SP);
    end

    assign cp_shift = {acc_reg[19:0], digit};

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        emit_cp   = 1'b0;
        cp_raw    = acc_reg;
        do_normal = 1'b0;
        plain_v   = 1'b0;
        unique case (mode_reg)
            cssd_pkg::MODE_BSL:
            begin
                mode_next = cssd_pkg::MODE_NORMAL;
                if (in_byte == cssd_pkg::CH_LF || in_byte == cssd_pkg::CH_FF)
                    mode_next = cssd_pkg::MODE_NORMAL;
                else if (in_byte == cssd_pkg::CH_CR)
                    mode_next = cssd_pkg::MODE_CR;
                else if (is_hex)
                begin
                    acc_next  = {20'd0, digit};
                    cnt_next  = 3'd1;
                    mode_next = cssd_pkg::MODE_HEX;
                end
                else
                    plain_v = 1'b1;
            end
            cssd_pkg::MODE_HEX:
            begin
                if (is_hex)
                begin
                    acc_next = cp_shift;
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg >= 3'd5)
                    begin
                        emit_cp   = 1'b1;
                        cp_raw    = cp_shift;
                        acc_next  = '0;
                        cnt_next  = '0;
                        mode_next = cssd_pkg::MODE_SWALLOW;
                    end
                end
                else
                begin
                    emit_cp   = 1'b1;
                    acc_next  = '0;
                    cnt_next  = '0;
                    mode_next = cssd_pkg::MODE_NORMAL;
                    do_normal = !is_ws;
                end
            end
            cssd_pkg::MODE_CR:
            begin
                mode_next = cssd_pkg::MODE_NORMAL;
                do_normal = (in_byte != cssd_pkg::CH_LF);
            end
            cssd_pkg::MODE_SWALLOW:
            begin
                mode_next = cssd_pkg::MODE_NORMAL;
                do_normal = !is_ws;
            end
            default:
                do_normal = 1'b1;
        endcase

        if (do_normal)
        begin
            mode_next = cssd_pkg::MODE_NORMAL;
            if (in_byte == cssd_pkg::CH_BSL && !in_last)
                mode_next = cssd_pkg::MODE_BSL;
            else
                plain_v = 1'b1;
        end

        if (in_last)
        begin
            if (mode_next == cssd_pkg::MODE_HEX)
            begin
                emit_cp = 1'b1;
                cp_raw  = acc_next;
            end
            mode_next = cssd_pkg::MODE_NORMAL;
            acc_next  = '0;
            cnt_next  = '0;
        end
    end

    // replace invalid code points, size the UTF-8 sequence
    always_comb
    begin
        if (cp_raw == 24'd0 || cp_raw > cssd_pkg::CP_MAX ||
            (cp_raw >= cssd_pkg::CP_SUR_LO && cp_raw <= cssd_pkg::CP_SUR_HI))
            cp_fix = cssd_pkg::CP_REPLACE;
        else
            cp_fix = cp_raw[20:0];
        if (cp_fix <= 21'h7F)
            cp_len = 3'd1;
        else if (cp_fix <= 21'h7FF)
            cp_len = 3'd2;
        else if (cp_fix <= 21'hFFFF)
            cp_len = 3'd3;
        else
            cp_len = 3'd4;
    end

    assign cmd.cp      = cp_fix;
    assign cmd.cp_len  = emit_cp ? cp_len : 3'd0;
    assign cmd.plain_v = plain_v;
    assign cmd.plain   = in_byte;
    assign cmd.last    = in_last;
    assign push        = accept && (emit_cp || plain_v || in_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cssd_pkg::MODE_NORMAL;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

    `ASSERT_CLK(a_last_resets_state, accept && in_last |=> mode_reg == cssd_pkg::MODE_NORMAL && cnt_reg == 3'd0 && acc_reg == 24'd0, "escape state not cleared at end of string")

endmodule

// ----- design/cssd_queue.sv -----
// Command queue between front and back end.
// Depends on cssd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cssd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cssd_pkg::cmd_t     wr_cmd,
    input  logic               pop,
    output cssd_pkg::cmd_t     rd_cmd,
    output logic               full,
    output logic               empty
);

    localparam int PW = $clog2(cssd_pkg::QDEPTH);
    localparam int CW = $clog2(cssd_pkg::QDEPTH + 1);

    cssd_pkg::cmd_t mem [cssd_pkg::QDEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full   = (count_reg == CW'(cssd_pkg::QDEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(cssd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(cssd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `ASSERT_NEVER(a_no_push_full, push && full, "push into full command queue")
    `ASSERT_NEVER(a_no_pop_empty, pop && empty, "pop from empty command queue")

endmodule

// ----- design/cssd_back.sv -----
// Back end: expand each command into output beats, one beat per cycle while the sink is ready.
// Depends on cssd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cssd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cssd_pkg::cmd_t     cmd,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               end_of_string,
    output logic               last_of_run
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       bv_reg, bv_next;
    logic       eos_reg, eos_next;
    logic       lor_reg, lor_next;

    logic [2:0] total;
    logic       marker, at_end, advance;

    assign total   = cmd.cp_len + {2'b00, cmd.plain_v};
    assign marker  = (total == 3'd0);
    assign at_end  = marker || (idx_reg == total - 3'd1);
    assign advance = !empty && (!valid_reg || out_ready);
    assign pop     = advance && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        bv_next    = bv_reg;
        eos_next   = eos_reg;
        lor_next   = lor_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            idx_next   = at_end ? 3'd0 : idx_reg + 3'd1;
            bv_next    = !marker;
            lor_next   = at_end;
            eos_next   = at_end && cmd.last;
            if (marker)
                byte_next = 8'h00;
            else if (idx_reg < cmd.cp_len)
                byte_next = cssd_pkg::utf8_byte(cmd.cp, cmd.cp_len, idx_reg);
            else
                byte_next = cmd.plain;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        bv_reg   <= bv_next;
        eos_reg  <= eos_next;
        lor_reg  <= lor_next;
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign byte_valid    = bv_reg;
    assign end_of_string = eos_reg;
    assign last_of_run   = lor_reg;

    `ASSERT_CLK(a_idx_idle_zero, empty |-> idx_reg == 3'd0, "beat index left mid-command with queue empty")

endmodule

// ----- design/css_escape_to_utf8_decoder_unit.sv -----
// CSS identifier escape decoder. Takes one raw identifier byte per input beat (tlast marks the
// final byte of a string) and returns the decoded bytes, escaped code points as UTF-8. The front
// end accepts one input beat per cycle while its 4-entry command queue has room; the back end
// sends one output beat per cycle while the sink is ready, and a byte yields 0 to 5 beats (one
// for an end-of-string marker). A byte that yields nothing costs no back-end time. The first
// output of a byte is registered in the command queue, then in the back-end output register.
// Depends on cssd_pkg, cssd_front, cssd_queue, cssd_back.
module css_escape_to_utf8_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] last_of_run
    output logic       m_axis_tlast    // end_of_string
);

    cssd_pkg::cmd_t wr_cmd, rd_cmd;
    logic           push, pop, full, empty;
    logic           byte_valid, last_of_run;

    cssd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_full   (full),
        .in_ready (s_axis_tready),
        .push     (push),
        .cmd      (wr_cmd)
    );

    cssd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .rd_cmd (rd_cmd),
        .full   (full),
        .empty  (empty)
    );

    cssd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (rd_cmd),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (m_axis_tdata),
        .byte_valid    (byte_valid),
        .end_of_string (m_axis_tlast),
        .last_of_run   (last_of_run)
    );

    assign m_axis_tuser = {last_of_run, byte_valid};

endmodule

// ----- bench/css_escape_to_utf8_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for css_escape_to_utf8_decoder_unit: random escaped identifier strings
// in, decoded UTF-8 beats out, compared against an in-bench decoder model.
// Depends on cssd_pkg and the decoder RTL.
module css_escape_to_utf8_decoder_unit_tb;

    localparam int LONG_HOLD = 200;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_LA = 8'h61;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       eos;
        logic       lor;
    } out_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    in_beat_t   raw_q[$];
    out_beat_t  decoded_q[$];
    logic [7:0] run_q[$];
    in_beat_t   drv_beat;
    out_beat_t  want;

    logic [2:0]  dec_mode = cssd_pkg::MODE_NORMAL;
    logic [23:0] dec_acc = 24'd0;
    logic [2:0]  dec_cnt = 3'd0;

    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    logic hold_req = 1'b0;
    int   hold_count = 0;
    logic in_taken = 1'b0;
    int   bytes_queued = 0;
    int   bytes_sent = 0;
    int   fail_count = 0;

    css_escape_to_utf8_decoder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic is_space(input logic [7:0] b);
        return b == cssd_pkg::CH_TAB || b == cssd_pkg::CH_LF || b == cssd_pkg::CH_FF ||
               b == cssd_pkg::CH_CR || b == cssd_pkg::CH_SP;
    endfunction

    function automatic int hex_digit_val(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return int'(b) - 'h30;
        if (b >= 8'h61 && b <= 8'h66)
            return int'(b) - 'h61 + 10;
        if (b >= 8'h41 && b <= 8'h46)
            return int'(b) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void add_run(input logic [7:0] b);
        run_q.insert(run_q.size(), b);
    endfunction

    function automatic void push_code_point(input logic [23:0] raw);
        logic [23:0] cp;
        cp = raw;
        if (cp == 24'd0 || cp > cssd_pkg::CP_MAX ||
            (cp >= cssd_pkg::CP_SUR_LO && cp <= cssd_pkg::CP_SUR_HI))
            cp = {3'b000, cssd_pkg::CP_REPLACE};
        if (cp <= 24'h00007F)
        begin
            add_run(cp[7:0]);
        end
        else if (cp <= 24'h0007FF)
        begin
            add_run(cssd_pkg::LEAD2 | {3'b000, cp[10:6]});
            add_run(cssd_pkg::CONT | {2'b00, cp[5:0]});
        end
        else if (cp <= 24'h00FFFF)
        begin
            add_run(cssd_pkg::LEAD3 | {4'b0000, cp[15:12]});
            add_run(cssd_pkg::CONT | {2'b00, cp[11:6]});
            add_run(cssd_pkg::CONT | {2'b00, cp[5:0]});
        end
        else
        begin
            add_run(cssd_pkg::LEAD4 | {5'b00000, cp[20:18]});
            add_run(cssd_pkg::CONT | {2'b00, cp[17:12]});
            add_run(cssd_pkg::CONT | {2'b00, cp[11:6]});
            add_run(cssd_pkg::CONT | {2'b00, cp[5:0]});
        end
    endfunction

    function automatic void copy_plain(input logic [7:0] b, input logic last);
        dec_mode = cssd_pkg::MODE_NORMAL;
        if (b == cssd_pkg::CH_BSL)
        begin
            if (last)
                add_run(cssd_pkg::CH_BSL);
            else
                dec_mode = cssd_pkg::MODE_BSL;
        end
        else
        begin
            add_run(b);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int        d;
        int        k;
        out_beat_t ob;
        d = hex_digit_val(b);
        run_q.delete();
        case (dec_mode)
            cssd_pkg::MODE_BSL:
            begin
                dec_mode = cssd_pkg::MODE_NORMAL;
                if (b == cssd_pkg::CH_CR)
                begin
                    dec_mode = cssd_pkg::MODE_CR;
                end
                else if (b != cssd_pkg::CH_LF && b != cssd_pkg::CH_FF)
                begin
                    if (d >= 0)
                    begin
                        dec_acc = {20'd0, d[3:0]};
                        dec_cnt = 3'd1;
                        dec_mode = cssd_pkg::MODE_HEX;
                    end
                    else
                    begin
                        add_run(b);
                    end
                end
            end
            cssd_pkg::MODE_HEX:
            begin
                if (d >= 0)
                begin
                    dec_acc = {dec_acc[19:0], d[3:0]};
                    dec_cnt = dec_cnt + 3'd1;
                    if (dec_cnt >= 3'd6)
                    begin
                        push_code_point(dec_acc);
                        dec_acc = 24'd0;
                        dec_cnt = 3'd0;
                        dec_mode = cssd_pkg::MODE_SWALLOW;
                    end
                end
                else
                begin
                    push_code_point(dec_acc);
                    dec_acc = 24'd0;
                    dec_cnt = 3'd0;
                    dec_mode = cssd_pkg::MODE_NORMAL;
                    if (!is_space(b))
                        copy_plain(b, last);
                end
            end
            cssd_pkg::MODE_CR:
            begin
                dec_mode = cssd_pkg::MODE_NORMAL;
                if (b != cssd_pkg::CH_LF)
                    copy_plain(b, last);
            end
            cssd_pkg::MODE_SWALLOW:
            begin
                dec_mode = cssd_pkg::MODE_NORMAL;
                if (!is_space(b))
                    copy_plain(b, last);
            end
            default:
                copy_plain(b, last);
        endcase
        if (last)
        begin
            if (dec_mode == cssd_pkg::MODE_HEX)
                push_code_point(dec_acc);
            dec_mode = cssd_pkg::MODE_NORMAL;
            dec_acc = 24'd0;
            dec_cnt = 3'd0;
        end
        if (last && run_q.size() == 0)
        begin
            ob.data = 8'h00;
            ob.valid = 1'b0;
            ob.eos = 1'b1;
            ob.lor = 1'b1;
            decoded_q.insert(decoded_q.size(), ob);
        end
        else
        begin
            for (k = 0; k < run_q.size(); k++)
            begin
                ob.data = run_q[k];
                ob.valid = 1'b1;
                ob.eos = last && (k == run_q.size() - 1);
                ob.lor = (k == run_q.size() - 1);
                decoded_q.insert(decoded_q.size(), ob);
            end
        end
    endfunction

    // drive input beats; hold a beat until it is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (raw_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                drv_beat = raw_q.pop_front();
                s_axis_tdata <= drv_beat.data;
                s_axis_tlast <= drv_beat.last;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output ready, with random stalls and a single long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            if (hold_count < LONG_HOLD)
            begin
                hold_count = hold_count + 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                hold_count = 0;
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // check output beats, then predict from the accepted input beat
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("unexpected output beat: out_byte %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.data)
                begin
                    $error("out_byte: expected %h, got %h", want.data, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== want.valid)
                begin
                    $error("byte_valid: expected %b, got %b", want.valid, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.eos)
                begin
                    $error("end_of_string: expected %b, got %b", want.eos, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser[1] !== want.lor)
                begin
                    $error("last_of_run: expected %b, got %b", want.lor, m_axis_tuser[1]);
                    fail_count++;
                end
            end
        end
        in_taken = s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            decode_byte(s_axis_tdata, s_axis_tlast);
            bytes_sent++;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic last);
        in_beat_t ib;
        ib.data = b;
        ib.last = last;
        raw_q.insert(raw_q.size(), ib);
        bytes_queued++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CH_0 + {4'd0, n};
        return (($urandom_range(1) != 0) ? CH_UA : CH_LA) + {4'd0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(4))
            0:       return cssd_pkg::CH_TAB;
            1:       return cssd_pkg::CH_LF;
            2:       return cssd_pkg::CH_FF;
            3:       return cssd_pkg::CH_CR;
            default: return cssd_pkg::CH_SP;
        endcase
    endfunction

    function automatic logic [23:0] pick_code_point();
        case ($urandom_range(9))
            0: return 24'($urandom_range(1, 'h7F));
            1: return 24'($urandom_range('h80, 'h7FF));
            2: return 24'($urandom_range('h800, 'hFFFF));
            3: return 24'($urandom_range('h10000, 'h10FFFF));
            4: return 24'($urandom_range('hD800, 'hDFFF));
            5: return 24'($urandom_range('h110000, 'hFFFFFF));
            6: return 24'd0;
            default:
                case ($urandom_range(13))
                    0:       return 24'h00007F;
                    1:       return 24'h000080;
                    2:       return 24'h0007FF;
                    3:       return 24'h000800;
                    4:       return 24'h00D7FF;
                    5:       return 24'h00D800;
                    6:       return 24'h00DFFF;
                    7:       return 24'h00E000;
                    8:       return 24'h00FFFD;
                    9:       return 24'h00FFFF;
                    10:      return 24'h010000;
                    11:      return 24'h10FFFF;
                    12:      return 24'h110000;
                    default: return 24'hFFFFFF;
                endcase
        endcase
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (hex_digit_val(b) >= 0 || b == cssd_pkg::CH_LF || b == cssd_pkg::CH_FF ||
               b == cssd_pkg::CH_CR)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic add_string();
        logic [7:0]  str[$];
        logic [23:0] cp;
        int          n_tok;
        int          kind;
        int          need;
        int          ndig;
        int          i;
        int          t;
        n_tok = $urandom_range(1, 5);
        if ($urandom_range(7) == 0)
        begin
            // noise: loose bytes biased toward escape characters
            for (i = 0; i < n_tok * 2; i++)
                case ($urandom_range(3))
                    0:       str.insert(str.size(), cssd_pkg::CH_BSL);
                    1:       str.insert(str.size(), hex_char(4'($urandom_range(15))));
                    2:       str.insert(str.size(), space_char());
                    default: str.insert(str.size(), 8'($urandom_range(255)));
                endcase
        end
        else
        begin
            for (t = 0; t < n_tok; t++)
            begin
                kind = $urandom_range(99);
                if (kind < 35)
                begin
                    str.insert(str.size(), 8'($urandom_range(255)));
                end
                else if (kind < 50)
                begin
                    str.insert(str.size(), cssd_pkg::CH_BSL);
                    str.insert(str.size(),
                               ($urandom_range(3) == 0) ? cssd_pkg::CH_BSL : non_hex_char());
                end
                else if (kind < 60)
                begin
                    str.insert(str.size(), cssd_pkg::CH_BSL);
                    case ($urandom_range(3))
                        0: str.insert(str.size(), cssd_pkg::CH_LF);
                        1: str.insert(str.size(), cssd_pkg::CH_FF);
                        2: str.insert(str.size(), cssd_pkg::CH_CR);
                        default:
                        begin
                            str.insert(str.size(), cssd_pkg::CH_CR);
                            str.insert(str.size(), cssd_pkg::CH_LF);
                        end
                    endcase
                end
                else
                begin
                    cp = pick_code_point();
                    need = 1;
                    while (need < 6 && (cp >> (4 * need)) != 24'd0)
                        need++;
                    ndig = $urandom_range(need, 6);
                    str.insert(str.size(), cssd_pkg::CH_BSL);
                    for (i = ndig - 1; i >= 0; i--)
                        str.insert(str.size(), hex_char(4'(cp >> (4 * i))));
                    if ($urandom_range(1) == 0)
                        str.insert(str.size(), space_char());
                end
            end
        end
        case ($urandom_range(9))
            0: str.insert(str.size(), cssd_pkg::CH_BSL);
            1:
            begin
                str.insert(str.size(), cssd_pkg::CH_BSL);
                ndig = $urandom_range(1, 3);
                for (i = 0; i < ndig; i++)
                    str.insert(str.size(), hex_char(4'($urandom_range(15))));
            end
            default: ;
        endcase
        for (i = 0; i < str.size(); i++)
            queue_byte(str[i], i == str.size() - 1);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        while (bytes_sent != bytes_queued || decoded_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int half;
        int mark;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(cssd_pkg::CH_BSL, 1'b1);
        queue_byte(cssd_pkg::CH_BSL, 1'b0);
        queue_byte(cssd_pkg::CH_FF, 1'b1);
        queue_byte(cssd_pkg::CH_BSL, 1'b0);
        queue_byte(cssd_pkg::CH_CR, 1'b0);
        queue_byte(cssd_pkg::CH_LF, 1'b0);
        queue_byte(8'h7A, 1'b1);
        queue_byte(cssd_pkg::CH_BSL, 1'b0);
        queue_byte(8'h30, 1'b1);
        queue_byte(cssd_pkg::CH_BSL, 1'b0);
        queue_byte(8'h31, 1'b0);
        queue_byte(8'h30, 1'b0);
        queue_byte(8'h66, 1'b0);
        queue_byte(8'h46, 1'b0);
        queue_byte(8'h66, 1'b0);
        queue_byte(8'h46, 1'b0);
        queue_byte(8'h41, 1'b1);
        queue_byte(cssd_pkg::CH_BSL, 1'b0);
        queue_byte(8'h44, 1'b0);
        queue_byte(8'h38, 1'b0);
        queue_byte(8'h30, 1'b0);
        queue_byte(8'h30, 1'b0);
        queue_byte(cssd_pkg::CH_TAB, 1'b1);
        wait_drain();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 49;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 49;
                end
                default:
                begin
                    src_idle_pct = 6;
                    sink_stall_pct = 6;
                end
            endcase
            for (half = 0; half < 2; half++)
            begin
                mark = bytes_queued;
                while (bytes_queued - mark < 50)
                    add_string();
                if (ph == 0 && half == 0)
                    hold_req = 1'b1;
                wait_drain();
            end
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && decoded_q.size() == 0)
            $display("css_escape_to_utf8_decoder_unit_tb: clean");
        else
            $display("css_escape_to_utf8_decoder_unit_tb: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("css_escape_to_utf8_decoder_unit_tb: errors");
        $finish;
    end

endmodule
